FILE: rtl/pts_pkg.sv
package pts_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int CntW     = $clog2(MaxTasks + 1);

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_GET      = 3'd1,
    ACT_SELECT   = 3'd2,
    ACT_COMPLETE = 3'd3,
    ACT_DISABLE  = 3'd4,
    ACT_ADVANCE  = 3'd5
  } action_t;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_RUNNING   = 2'd1;
  localparam logic [1:0] ST_COMPLETED = 2'd2;
  localparam logic [1:0] ST_DISABLED  = 2'd3;

  localparam logic [1:0] RES_OK            = 2'd0;
  localparam logic [1:0] RES_FULL          = 2'd1;
  localparam logic [1:0] RES_NOT_FOUND     = 2'd2;
  localparam logic [1:0] RES_NONE_ELIGIBLE = 2'd3;

  typedef struct packed {
    logic [31:0] task_id;
    logic [15:0] priority_v;
    logic [1:0]  state;
    logic [15:0] run_limit;
    logic [15:0] runs_done;
    logic [31:0] ready_tick;
  } entry_t;

  // Best-so-far token kept by the controller and updated at each scan step
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
    logic [15:0]     prio;
  } scan_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic            wr;
    logic [IdxW-1:0] wr_idx;
    entry_t          wr_entry;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY,
    FSM_OUT
  } fsm_t;

endpackage

FILE: rtl/pts_if.sv
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] task_id;
  logic [15:0] priority_in;
  logic [1:0]  state_in;
  logic [15:0] max_runs_in;
  logic [15:0] runs_done_in;
  logic [31:0] ready_tick_in;
  logic [31:0] amount;
  logic [3:0]  entry_index;
  modport source (output valid, action, task_id, priority_in, state_in, max_runs_in,
                  runs_done_in, ready_tick_in, amount, entry_index, input ready);
  modport sink (input valid, action, task_id, priority_in, state_in, max_runs_in,
                runs_done_in, ready_tick_in, amount, entry_index, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_task_id;
  logic [15:0] out_priority;
  logic [1:0]  out_state;
  logic [15:0] out_max_runs;
  logic [15:0] out_runs_done;
  logic [31:0] out_ready_tick;
  logic [4:0]  entry_count;
  modport source (output valid, status, out_task_id, out_priority, out_state, out_max_runs,
                  out_runs_done, out_ready_tick, entry_count, input ready);
  modport sink (input valid, status, out_task_id, out_priority, out_state, out_max_runs,
                out_runs_done, out_ready_tick, entry_count, output ready);
endinterface

FILE: rtl/pts_cell.sv
module pts_cell import pts_pkg::*; (
  input  logic            clk,
  input  logic [IdxW-1:0] my_idx,
  input  cell_cmd_t       cmd,
  input  entry_t          shift_in,
  input  logic            shift_en,
  output entry_t          entry
);

  entry_t entry_r;

  // Load on write, otherwise rotate towards the head while scanning
  always_ff @(posedge clk) begin
    if (cmd.wr && cmd.wr_idx == my_idx) begin
      entry_r <= cmd.wr_entry;
    end else if (shift_en) begin
      entry_r <= shift_in;
    end
  end

  assign entry = entry_r;

endmodule

FILE: rtl/priority_task_scheduler_core.sv
// The result for add, get, advance and unused codes is built in the output state; select,
// mark completed and disable first scan the cell ring through one full rotation past the
// scan head, then update the found entry in the apply state.
// One item at a time: the next is taken only after the result has been accepted.
// Reset (rst_n, synchronous) clears the entry count, tick and control state only.
module priority_task_scheduler_core import pts_pkg::*; (
  input logic clk,
  input logic rst_n,
  pts_in_if.sink    in_ch,
  pts_out_if.source out_ch
);

  fsm_t              state_r, state_nxt;
  logic [CntW-1:0]   held_r, held_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [IdxW-1:0]   step_r, step_nxt;
  scan_t             scan_r, scan_nxt;
  action_t           act_r;
  logic [2:0]        act_raw_r;
  entry_t            in_e_r;
  logic [31:0]       id_r, amount_r;
  logic [3:0]        gidx_r;
  logic              valid_r;
  logic [1:0]        status_r;
  entry_t            res_r;
  cell_cmd_t         cmd;
  entry_t            cells [MaxTasks];
  logic              shift_en;

  // Ring of cells: each passes its entry to the lower neighbour while scanning,
  // so the head cell sees entry k at scan step k (ring is restored after one full rotation).
  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    pts_cell u_cell (
      .clk      (clk),
      .my_idx   (IdxW'(g)),
      .cmd      (cmd),
      .shift_in (cells[(g + 1) % MaxTasks]),
      .shift_en (shift_en),
      .entry    (cells[g])
    );
  end

  entry_t head;
  logic   head_live, head_elig, head_match;
  assign head       = cells[0];
  assign head_live  = {1'b0, step_r} < held_r;
  assign head_elig  = head.state == ST_PENDING &&
                      !(head.run_limit != 16'd0 && head.runs_done >= head.run_limit) &&
                      head.ready_tick <= tick_r;
  assign head_match = head.task_id == id_r;
  assign shift_en   = state_r == FSM_SCAN;

  assign in_ch.ready = state_r == FSM_IDLE && !valid_r;

  // Target of the apply step; the ring is back in place by then
  entry_t tgt, upd;
  logic [15:0] rd_inc;
  always_comb begin
    tgt    = cells[scan_r.idx];
    upd    = tgt;
    rd_inc = (tgt.runs_done != 16'hFFFF) ? tgt.runs_done + 16'd1 : tgt.runs_done;
    unique case (act_r)
      ACT_SELECT: upd.state = ST_RUNNING;
      ACT_COMPLETE: begin
        upd.runs_done = rd_inc;
        if (tgt.run_limit != 16'd0 && rd_inc >= tgt.run_limit) begin
          upd.state = ST_COMPLETED;
        end else begin
          upd.state      = ST_PENDING;
          upd.ready_tick = tick_r + amount_r;
        end
      end
      ACT_DISABLE: upd.state = ST_DISABLED;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    tick_nxt  = tick_r;
    step_nxt  = step_r;
    scan_nxt  = scan_r;
    cmd       = '0;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          step_nxt  = '0;
          scan_nxt  = '0;
          state_nxt = (in_ch.action == ACT_SELECT || in_ch.action == ACT_COMPLETE ||
                       in_ch.action == ACT_DISABLE) ? FSM_SCAN : FSM_OUT;
        end
      end
      FSM_SCAN: begin
        // Select keeps the strictly greater priority; lookups keep the first match
        if (head_live) begin
          if (act_r == ACT_SELECT) begin
            if (head_elig && (!scan_r.found || head.priority_v > scan_r.prio)) begin
              scan_nxt = '{found: 1'b1, idx: step_r, prio: head.priority_v};
            end
          end else if (head_match && !scan_r.found) begin
            scan_nxt = '{found: 1'b1, idx: step_r, prio: 16'd0};
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == IdxW'(MaxTasks - 1)) state_nxt = FSM_APPLY;
      end
      FSM_APPLY: begin
        if (scan_r.found) begin
          cmd.wr       = 1'b1;
          cmd.wr_idx   = scan_r.idx;
          cmd.wr_entry = upd;
        end
        state_nxt = FSM_IDLE;
      end
      FSM_OUT: begin
        if (act_r == ACT_ADD && held_r < CntW'(MaxTasks)) begin
          cmd.wr       = 1'b1;
          cmd.wr_idx   = held_r[IdxW-1:0];
          cmd.wr_entry = in_e_r;
          held_nxt     = held_r + 1'b1;
        end
        if (act_r == ACT_ADVANCE && act_raw_r == 3'(ACT_ADVANCE)) begin
          tick_nxt = tick_r + amount_r;
        end
        state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      held_r  <= '0;
      tick_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      tick_r  <= tick_nxt;
      if (state_r == FSM_APPLY || state_r == FSM_OUT) begin
        valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Latch the item and build the result
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    scan_r <= scan_nxt;
    if (in_ch.valid && in_ch.ready) begin
      act_raw_r <= in_ch.action;
      act_r     <= (in_ch.action > 3'(ACT_ADVANCE)) ? ACT_ADVANCE : action_t'(in_ch.action);
      id_r      <= in_ch.task_id;
      amount_r  <= in_ch.amount;
      gidx_r    <= in_ch.entry_index;
      in_e_r    <= '{task_id: in_ch.task_id, priority_v: in_ch.priority_in,
                     state: in_ch.state_in, run_limit: in_ch.max_runs_in,
                     runs_done: in_ch.runs_done_in, ready_tick: in_ch.ready_tick_in};
    end
    if (state_r == FSM_APPLY) begin
      if (act_r == ACT_SELECT) begin
        status_r <= scan_r.found ? RES_OK : RES_NONE_ELIGIBLE;
        res_r    <= scan_r.found ? upd : '0;
      end else begin
        status_r <= scan_r.found ? RES_OK : RES_NOT_FOUND;
        res_r    <= '0;
      end
    end else if (state_r == FSM_OUT) begin
      if (act_r == ACT_GET) begin
        if ({1'b0, gidx_r} >= held_r || 5'(gidx_r) >= 5'(MaxTasks)) begin
          status_r <= RES_NOT_FOUND;
          res_r    <= '0;
        end else begin
          status_r <= RES_OK;
          res_r    <= cells[gidx_r[IdxW-1:0]];
        end
      end else begin
        status_r <= (act_r == ACT_ADD && held_r >= CntW'(MaxTasks)) ? RES_FULL : RES_OK;
        res_r    <= '0;
      end
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.out_task_id    = res_r.task_id;
  assign out_ch.out_priority   = res_r.priority_v;
  assign out_ch.out_state      = res_r.state;
  assign out_ch.out_max_runs   = res_r.run_limit;
  assign out_ch.out_runs_done  = res_r.runs_done;
  assign out_ch.out_ready_tick = res_r.ready_tick;
  assign out_ch.entry_count    = 5'(held_r);

  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CntW'(MaxTasks)) else $error("entry count beyond capacity");
  a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != $past(held_r) |-> held_r == $past(held_r) + 1'b1)
    else $error("entry count moved by other than one");
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_APPLY |-> $past(step_r) == IdxW'(MaxTasks - 1))
    else $error("apply before full rotation");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != FSM_IDLE |-> !in_ch.ready) else $error("ready while busy");

endmodule
